[sv/aabb_pkg.sv]
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants of the contact event tracker
// Holds the transaction payloads, the event codes, the controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aabb_pkg;

	localparam int ID_W              = 6;
	localparam int COORD_W           = 16;
	localparam int MAX_COLLIDERS_DEF = 64;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_ENTER = 2'd1,
		EV_STAY  = 2'd2,
		EV_EXIT  = 2'd3
	} contact_ev_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]           left_id;
		logic [ID_W-1:0]           right_cid;
		logic signed [COORD_W-1:0] left_x;
		logic signed [COORD_W-1:0] left_y;
		logic [COORD_W-1:0]        left_w;
		logic [COORD_W-1:0]        left_h;
		logic signed [COORD_W-1:0] right_x;
		logic signed [COORD_W-1:0] right_y;
		logic [COORD_W-1:0]        right_w;
		logic [COORD_W-1:0]        right_h;
		logic                      either_dead;
		logic                      pair_active;
	} pair_t;

	typedef struct packed {
		contact_ev_t event_res;
		logic        overlap;
	} result_t;

	typedef struct packed {
		logic load_in;
		logic eval_fire;
		logic clear_wr;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

[sv/aabb_ram.sv]
// ----------------------------------------------------------------------------
// aabb_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read; the read data
// holds while the read enable is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/aabb_ctrl.sv]
// ----------------------------------------------------------------------------
// aabb_ctrl: sequencing state machine of the contact event tracker
// Runs the clearing pass after reset, then accepts one transaction, lets the
// datapath evaluate it and returns to idle once the result is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pair_valid,
	output logic                pair_stall,
	input  wire aabb_pkg::stat_t stat,
	output aabb_pkg::cmd_t      cmd
);

	import aabb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (pair_valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		pair_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			S_IDLE: begin
				pair_stall  = 1'b0;
				cmd.load_in = pair_valid;
			end
			S_EVAL: begin
				cmd.eval_fire = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

[sv/aabb_datapath.sv]
// ----------------------------------------------------------------------------
// aabb_datapath: overlap test, contact bit store and result register
// Registers the accepted pair, reads its contact bit, decides the event,
// writes the bit back and holds the result until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_datapath #(
	parameter int MAX_COLLIDERS = aabb_pkg::MAX_COLLIDERS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire aabb_pkg::cmd_t   cmd,
	output aabb_pkg::stat_t       stat,
	input  wire aabb_pkg::pair_t  pair,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output aabb_pkg::result_t     result
);

	import aabb_pkg::*;

	// Ids are ID_W bits wide, so no more rows than that can ever be reached.
	localparam int ID_LIMIT = (MAX_COLLIDERS < (1 << ID_W)) ? MAX_COLLIDERS : (1 << ID_W);
	localparam int DEPTH    = ID_LIMIT * ID_LIMIT;
	localparam int AW       = $clog2(DEPTH);
	localparam logic [AW-1:0] ROW_STRIDE = AW'(ID_LIMIT);
	localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
	localparam logic [ID_W:0] ID_BOUND   = (ID_W + 1)'(ID_LIMIT);

	// Exact test of 2*|c1 - c0| <= s0 + s1.
	function automatic logic axis_hit(
		input logic [COORD_W-1:0] c0,
		input logic [COORD_W-1:0] s0,
		input logic [COORD_W-1:0] c1,
		input logic [COORD_W-1:0] s1
	);
		logic [COORD_W:0] diff;
		logic [COORD_W:0] mag;
		logic [COORD_W:0] sum;
		diff = {c1[COORD_W-1], c1} - {c0[COORD_W-1], c0};
		mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;
		sum  = {1'b0, s0} + {1'b0, s1};
		return {mag, 1'b0} <= {1'b0, sum};
	endfunction

	pair_t       pair_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] clr_addr_q;
	result_t     out_q;
	logic        out_valid_q;

	logic [AW-1:0] rd_addr;
	logic [0:0]    rd_bit;
	logic          was;
	logic          pair_ok;
	logic          hit;
	logic          new_bit;
	contact_ev_t   ev;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [0:0]    ram_wdata;

	assign rd_addr = AW'(pair.left_id) * ROW_STRIDE + AW'(pair.right_cid);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pair_q <= pair;
			addr_q <= rd_addr;
		end
		if (cmd.eval_fire) begin
			out_q.event_res <= ev;
			out_q.overlap   <= hit & pair_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_wr) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.eval_fire) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign was     = rd_bit[0];
	assign pair_ok = pair_q.pair_active
		&& (pair_q.left_id != pair_q.right_cid)
		&& ({1'b0, pair_q.left_id} < ID_BOUND)
		&& ({1'b0, pair_q.right_cid} < ID_BOUND);
	assign hit = axis_hit(pair_q.left_x, pair_q.left_w, pair_q.right_x, pair_q.right_w)
		&& axis_hit(pair_q.left_y, pair_q.left_h, pair_q.right_y, pair_q.right_h);

	always_comb begin
		ev      = EV_NONE;
		new_bit = was;
		if (pair_ok) begin
			if (hit) begin
				if (!was) begin
					if (!pair_q.either_dead) begin
						ev      = EV_ENTER;
						new_bit = 1'b1;
					end
				end else if (pair_q.either_dead) begin
					ev      = EV_EXIT;
					new_bit = 1'b0;
				end else begin
					ev = EV_STAY;
				end
			end else if (was) begin
				ev      = EV_EXIT;
				new_bit = 1'b0;
			end
		end
	end

	assign ram_we    = cmd.clear_wr | (cmd.eval_fire & pair_ok);
	assign ram_waddr = cmd.clear_wr ? clr_addr_q : addr_q;
	assign ram_wdata = cmd.clear_wr ? 1'b0 : new_bit;

	aabb_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_flags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.load_in),
		.raddr (rd_addr),
		.rdata (rd_bit)
	);

	assign stat.clear_last = (clr_addr_q == LAST_ADDR);
	assign stat.out_free   = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// A fired evaluation always leaves a result for the consumer.
	a_fire_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval_fire |=> out_valid_q)
		else $error("evaluated transaction left no result");

	// A rejected pair never reports an event or an overlap.
	a_reject_none: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval_fire && !pair_ok) |=> (out_q.event_res == EV_NONE && !out_q.overlap))
		else $error("rejected pair produced an event");

	// Enter and stay are only ever reported with the overlap bit set.
	a_enter_stay_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval_fire |=> ((out_q.event_res != EV_ENTER && out_q.event_res != EV_STAY)
			|| out_q.overlap))
		else $error("enter or stay without overlap");

	// The clearing pass never overlaps with accepting or evaluating a pair.
	a_clear_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> (!cmd.load_in && !cmd.eval_fire))
		else $error("pair traffic during clearing pass");

endmodule

`default_nettype wire

[sv/aabb_contact_event_tracker.sv]
// ----------------------------------------------------------------------------
// aabb_contact_event_tracker: box overlap test with enter, stay, exit events
// Tests one ordered collider pair per transaction and tracks its contact bit.
// ----------------------------------------------------------------------------
// Each pair transaction carries two collider ids and two boxes given as
// centre and size; the boxes overlap when, on both axes, twice the absolute
// centre distance is no more than the sum of the sizes, which is evaluated
// exactly in integer arithmetic. One contact bit is kept per ordered pair of
// ids and the block reports enter, stay, exit or none while updating that
// bit; an inactive pair, equal ids or an id at or above MAX_COLLIDERS gives
// none with the overlap bit low and leaves the bit untouched. A pair is
// accepted in the idle state, where its contact bit is read from the flag
// RAM, whose read port is registered; in the evaluation state the overlap
// is tested, the event decided, the bit written back and the result loaded
// into the output register. A result that waits to be taken does not block
// the next pair from being accepted, but a second evaluation waits for the
// output register to free up. After reset the flag RAM is cleared one entry
// per cycle, all min(MAX_COLLIDERS, 64) squared entries of it (4096 with the
// default setting); pair_stall stays high during that pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_contact_event_tracker #(
	parameter int MAX_COLLIDERS = aabb_pkg::MAX_COLLIDERS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pair_valid,
	output logic                   pair_stall,
	input  wire aabb_pkg::pair_t   pair,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output aabb_pkg::result_t      result
);

	import aabb_pkg::*;

	// The controller and the datapath exchange nothing but these two bundles.
	cmd_t  cmd;
	stat_t stat;

	// The state machine owns the input handshake and decides in which cycle
	// the datapath loads a transaction, evaluates it or clears a flag entry.
	aabb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	// The datapath holds the pair register, the flag RAM, the clear counter
	// and the output register that drives the result channel.
	aabb_datapath #(
		.MAX_COLLIDERS (MAX_COLLIDERS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.pair         (pair),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

[test/aabb_contact_event_tracker_tb.sv]
// ----------------------------------------------------------------------------
// aabb_contact_event_tracker_tb: self-checking bench for the contact tracker
// Streams collider pair transactions through the tracker under random idling
// on both sides, predicts each event and overlap bit from its own copy of the
// contact bits, and checks every result transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_contact_event_tracker_tb;

	import aabb_pkg::*;

	// The tracker keeps one contact bit per ordered pair of ids.
	localparam int CONTACT_SLOTS = MAX_COLLIDERS_DEF * MAX_COLLIDERS_DEF;
	// Number of random pair transactions after the directed ones.
	localparam int RANDOM_PAIRS = 1950;
	// Cycles without any accepted transaction before the run is abandoned.
	// The flag clearing pass after reset also counts toward this limit.
	localparam int IDLE_LIMIT = 12000;
	// Cycles the receiver holds off in one stretch to back the block up.
	localparam int LONG_HOLD = 200;
	// Number of results after which that long hold-off happens.
	localparam int HOLD_AFTER = 500;
	// Cycles allowed after the last expected result for stray results.
	localparam int DRAIN_CYCLES = 20;

	// ------------------------------------------------------------------------
	// Contact predictor and result store.
	// ------------------------------------------------------------------------
	class contact_scoreboard;
		bit      contact_bits [CONTACT_SLOTS];
		result_t expected_q [$];
		int      mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Exact overlap along one axis: 2 * |c1 - c0| <= s0 + s1.
		function bit axis_hit(logic signed [COORD_W-1:0] c0, logic [COORD_W-1:0] s0,
				logic signed [COORD_W-1:0] c1, logic [COORD_W-1:0] s1);
			longint sep;
			longint span;
			sep  = longint'(c1) - longint'(c0);
			span = longint'(s0) + longint'(s1);
			if (sep < 0)
				sep = -sep;
			return (2 * sep <= span);
		endfunction

		function void note_pair(pair_t p);
			result_t                exp_r;
			logic [2*ID_W-1:0]      slot;
			bit                     hit;
			bit                     was;
			exp_r.event_res = EV_NONE;
			exp_r.overlap   = 1'b0;
			// Inactive pairs and self pairs leave everything untouched.
			if (p.pair_active && p.left_id != p.right_cid) begin
				slot = {p.left_id, p.right_cid};
				hit  = axis_hit(p.left_x, p.left_w, p.right_x, p.right_w) &&
					axis_hit(p.left_y, p.left_h, p.right_y, p.right_h);
				was  = contact_bits[slot];
				exp_r.overlap = hit;
				if (hit) begin
					if (!was) begin
						// A dying owner never starts a contact.
						if (!p.either_dead) begin
							exp_r.event_res    = EV_ENTER;
							contact_bits[slot] = 1'b1;
						end
					end else if (p.either_dead) begin
						exp_r.event_res    = EV_EXIT;
						contact_bits[slot] = 1'b0;
					end else begin
						exp_r.event_res = EV_STAY;
					end
				end else if (was) begin
					exp_r.event_res    = EV_EXIT;
					contact_bits[slot] = 1'b0;
				end
			end
			expected_q.push_back(exp_r);
		endfunction

		function void check_result(result_t r);
			result_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: event %0d overlap %0b", r.event_res,
						r.overlap);
			end else begin
				e = expected_q.pop_front();
				if (r.event_res !== e.event_res || r.overlap !== e.overlap) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected event %0d overlap %0b, got event %0d overlap %0b",
							e.event_res, e.overlap, r.event_res, r.overlap);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block under test.
	// ------------------------------------------------------------------------
	logic    clk;
	logic    arst_n;
	logic    pair_valid;
	logic    pair_stall;
	pair_t   pair;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	contact_scoreboard sb;
	int                idle_cycles = 0;

	aabb_contact_event_tracker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pair_valid   (pair_valid),
		.pair_stall   (pair_stall),
		.pair         (pair),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Monitor: every accepted transaction is seen here at the rising edge.
	// The result is checked before the pair of the same edge is noted, so a
	// result can never be matched against a pair accepted in the same cycle.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n === 1'b1 && sb != null) begin
			if (result_valid === 1'b1 && result_stall === 1'b0)
				sb.check_result(result);
			if (pair_valid === 1'b1 && pair_stall === 1'b0)
				sb.note_pair(pair);
		end
	end

	// Watchdog: counts cycles without any transaction on either channel.
	always @(posedge clk) begin
		if ((pair_valid === 1'b1 && pair_stall === 1'b0) ||
				(result_valid === 1'b1 && result_stall === 1'b0))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------

	// Offers one pair transaction after a gap of idle cycles and returns at
	// the rising edge where it is accepted. Each falling edge carries exactly
	// one assignment to pair_valid, so back to back transactions keep valid
	// high without a glitch.
	task automatic send_pair(pair_t p, int gap);
		repeat (gap) begin
			@(negedge clk);
			pair_valid <= 1'b0;
		end
		@(negedge clk);
		pair       <= p;
		pair_valid <= 1'b1;
		do
			@(posedge clk);
		while (pair_stall !== 1'b0);
	endtask

	// Lowers valid once the last offered transaction has been accepted.
	task automatic stop_sending();
		@(negedge clk);
		pair_valid <= 1'b0;
	endtask

	function automatic pair_t build_pair(int lid, int rid, int lx, int ly, int lw, int lh,
			int rx, int ry, int rw, int rh, bit dead, bit active);
		pair_t p;
		p.left_id     = lid[ID_W-1:0];
		p.right_cid   = rid[ID_W-1:0];
		p.left_x      = lx[COORD_W-1:0];
		p.left_y      = ly[COORD_W-1:0];
		p.left_w      = lw[COORD_W-1:0];
		p.left_h      = lh[COORD_W-1:0];
		p.right_x     = rx[COORD_W-1:0];
		p.right_y     = ry[COORD_W-1:0];
		p.right_w     = rw[COORD_W-1:0];
		p.right_h     = rh[COORD_W-1:0];
		p.either_dead = dead;
		p.pair_active = active;
		return p;
	endfunction

	// Builds one axis of a box pair. Kind 0 overlaps, at most just touching,
	// kind 1 sits within two units of the touching distance, any other kind
	// is clearly apart.
	function automatic void gen_axis(input int kind, output logic [COORD_W-1:0] c0,
			output logic [COORD_W-1:0] s0, output logic [COORD_W-1:0] c1,
			output logic [COORD_W-1:0] s1);
		int a;
		int b;
		int d;
		int base;
		int far;
		a = $urandom_range(0, 4000);
		b = $urandom_range(0, 4000);
		case (kind)
			0: d = $urandom_range(0, (a + b) / 2);
			1: d = (a + b) / 2 + int'($urandom_range(0, 4)) - 2;
			default: begin
				far = $urandom_range(0, 6000);
				d   = (a + b) / 2 + 1 + far;
			end
		endcase
		if (d < 0)
			d = 0;
		if ($urandom_range(0, 1) == 1)
			d = -d;
		base = int'($urandom_range(0, 20000)) - 10000;
		d    = base + d;
		c0   = base[COORD_W-1:0];
		c1   = d[COORD_W-1:0];
		s0   = a[COORD_W-1:0];
		s1   = b[COORD_W-1:0];
	endfunction

	// A pair as a scene walk would produce it: ids from a small working set
	// so the contact bits are revisited, boxes that mostly touch or nearly so.
	function automatic pair_t gen_scene_pair(logic [ID_W-1:0] lid, logic [ID_W-1:0] rid);
		pair_t             p;
		int                pick;
		int                kx;
		int                ky;
		int                swap_tmp;
		logic [COORD_W-1:0] c0, s0, c1, s1;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			kx = 0;
			ky = 0;
		end else if (pick < 70) begin
			kx = 1;
			ky = $urandom_range(0, 1);
		end else begin
			kx = 2;
			ky = $urandom_range(0, 2);
		end
		if ($urandom_range(0, 1) == 1) begin
			swap_tmp = kx;
			kx       = ky;
			ky       = swap_tmp;
		end
		p.left_id   = lid;
		p.right_cid = rid;
		gen_axis(kx, c0, s0, c1, s1);
		p.left_x  = c0;
		p.left_w  = s0;
		p.right_x = c1;
		p.right_w = s1;
		gen_axis(ky, c0, s0, c1, s1);
		p.left_y  = c0;
		p.left_h  = s0;
		p.right_y = c1;
		p.right_h = s1;
		p.either_dead = ($urandom_range(0, 9) == 0);
		p.pair_active = ($urandom_range(0, 11) != 0);
		return p;
	endfunction

	// ------------------------------------------------------------------------
	// Receiver: holds off for a random stretch before taking each result, with
	// runs of no stalling, and once holds off for a long stretch so that the block
	// fills up and stalls the pair channel.
	// ------------------------------------------------------------------------
	initial begin : receiver
		int  wait_cycles;
		int  taken;
		bit  held;
		taken        = 0;
		held         = 1'b0;
		result_stall = 1'b0;
		forever begin
			if (!held && taken == HOLD_AFTER) begin
				held        = 1'b1;
				wait_cycles = LONG_HOLD;
			end else if ((taken % 400) < 80) begin
				wait_cycles = 0;
			end else begin
				wait_cycles = $urandom_range(0, 7);
			end
			repeat (wait_cycles) begin
				@(negedge clk);
				result_stall <= 1'b1;
			end
			@(negedge clk);
			result_stall <= 1'b0;
			do
				@(posedge clk);
			while (result_valid !== 1'b1);
			taken++;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence: reset, directed pairs, random pairs, drain, verdict.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		pair_t              directed_q [$];
		pair_t              p;
		logic [ID_W-1:0]    id_pool [10];
		logic [191:0]       noise;
		int                 gap;
		int                 n;

		sb         = new();
		pair_valid = 1'b0;
		pair       = '0;
		arst_n     = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Pair (1,2) walks through enter, stay, exit on a dying
		// owner, the dying owner that cannot enter, and exit on separation.
		directed_q.push_back(build_pair(1, 2, 0, 0, 32, 32, 8, 8, 32, 32, 0, 1));
		directed_q.push_back(build_pair(1, 2, 0, 0, 32, 32, 8, 8, 32, 32, 0, 1));
		directed_q.push_back(build_pair(1, 2, 0, 0, 32, 32, 8, 8, 32, 32, 1, 1));
		directed_q.push_back(build_pair(1, 2, 0, 0, 32, 32, 8, 8, 32, 32, 1, 1));
		directed_q.push_back(build_pair(1, 2, 0, 0, 32, 32, 8, 8, 32, 32, 0, 1));
		directed_q.push_back(build_pair(1, 2, 0, 0, 32, 32, 900, 8, 32, 32, 0, 1));
		directed_q.push_back(build_pair(1, 2, 0, 0, 32, 32, 900, 8, 32, 32, 0, 1));
		// The reversed pair owns its own contact bit.
		directed_q.push_back(build_pair(2, 1, 5, 5, 20, 20, 5, 5, 20, 20, 0, 1));
		// An inactive pair reports nothing and keeps the bit of (2,1).
		directed_q.push_back(build_pair(2, 1, 0, 0, 20, 20, 5000, 0, 20, 20, 0, 0));
		directed_q.push_back(build_pair(2, 1, 5, 5, 20, 20, 5, 5, 20, 20, 0, 1));
		// Overlapping inactive pair and overlapping self pair.
		directed_q.push_back(build_pair(7, 9, 0, 0, 100, 100, 0, 0, 100, 100, 0, 0));
		directed_q.push_back(build_pair(5, 5, 0, 0, 100, 100, 0, 0, 100, 100, 0, 1));
		// Coordinate extremes: opposite ends of the range with full sizes
		// just touch and one unit less misses, on the widest ids.
		directed_q.push_back(build_pair(0, 63, -32768, 32767, 65535, 65535,
			32767, -32768, 65535, 65535, 0, 1));
		directed_q.push_back(build_pair(63, 0, -32768, -32768, 65535, 0,
			32767, -32768, 65534, 0, 0, 1));
		// Zero sized boxes at one point overlap.
		directed_q.push_back(build_pair(62, 61, 32767, 32767, 0, 0, 32767, 32767, 0, 0, 0, 1));
		// Exact touching along x, then one unit apart.
		directed_q.push_back(build_pair(3, 4, 0, 0, 16, 16, 16, 0, 16, 16, 0, 1));
		directed_q.push_back(build_pair(3, 4, 0, 0, 16, 16, 17, 0, 16, 16, 0, 1));
		// Touching on x but apart on y gives no contact.
		directed_q.push_back(build_pair(10, 11, 0, 0, 16, 16, 16, 17, 16, 16, 0, 1));
		// Odd size sum: distance 8 with sizes 8 and 9 touches, 9 does not.
		directed_q.push_back(build_pair(12, 13, -4, 0, 8, 8, 4, 0, 9, 8, 0, 1));
		directed_q.push_back(build_pair(12, 13, -4, 0, 8, 8, 5, 0, 9, 8, 0, 1));
		// All ones and all zeros.
		directed_q.push_back(build_pair(63, 63, -1, -1, 65535, 65535, -1, -1, 65535, 65535,
			1, 1));
		directed_q.push_back(build_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		foreach (directed_q[i])
			send_pair(directed_q[i], $urandom_range(0, 7));

		// Random part: mostly scene walk pairs over a working set of ids that
		// changes slowly, the rest random transactions, half with ids from the set.
		foreach (id_pool[i])
			id_pool[i] = ID_W'($urandom_range(0, 63));
		for (n = 0; n < RANDOM_PAIRS; n++) begin
			if (n % 300 == 299)
				id_pool[$urandom_range(0, 9)] = ID_W'($urandom_range(0, 63));
			if ($urandom_range(0, 99) < 72) begin
				p = gen_scene_pair(id_pool[$urandom_range(0, 9)], id_pool[$urandom_range(0, 9)]);
			end else begin
				noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
				p     = noise[$bits(pair_t)-1:0];
				if ($urandom_range(0, 1) == 1) begin
					p.left_id   = id_pool[$urandom_range(0, 9)];
					p.right_cid = id_pool[$urandom_range(0, 9)];
				end
			end
			// Every fourth stretch of 150 transactions runs without gaps.
			if ((n / 150) % 4 == 3)
				gap = 0;
			else
				gap = $urandom_range(0, 7);
			send_pair(p, gap);
			// Once in the middle, let the block drain completely.
			if (n == RANDOM_PAIRS / 2) begin
				stop_sending();
				while (sb.pending() != 0)
					@(posedge clk);
			end
		end
		stop_sending();

		// Drain, then leave room for any result that should not come.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
sv/aabb_pkg.sv
sv/aabb_ram.sv
sv/aabb_ctrl.sv
sv/aabb_datapath.sv
sv/aabb_contact_event_tracker.sv
test/aabb_contact_event_tracker_tb.sv
